// File: hw/rtl/scfb_pkg.sv
// Shared types and constants for the servo command frame builder.
// Used by every module of the block; depends on nothing else.
package scfb_pkg;

    // Frame layout constants.
    localparam int MAX_PAYLOAD    = 4;
    localparam int PAYLOAD_FIELDS = 4;
    localparam int LEN_W          = 3;
    localparam int FRAME_OVERHEAD = 6;
    localparam int FRAME_MAX      = MAX_PAYLOAD + FRAME_OVERHEAD;
    localparam int POS_W          = $clog2(FRAME_MAX);
    localparam int PIDX_W         = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int QUEUE_DEPTH    = 2;
    localparam int QPTR_W         = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] FRAME_HEADER = 8'h55;
    localparam logic [7:0] LEN_OFFSET   = 8'd3;

    // Byte positions within a frame.
    localparam logic [POS_W-1:0] POS_HDR0    = POS_W'(0);
    localparam logic [POS_W-1:0] POS_HDR1    = POS_W'(1);
    localparam logic [POS_W-1:0] POS_ID      = POS_W'(2);
    localparam logic [POS_W-1:0] POS_LEN     = POS_W'(3);
    localparam logic [POS_W-1:0] POS_CMD     = POS_W'(4);
    localparam logic [POS_W-1:0] POS_PAYLOAD = POS_W'(5);

    // One classified command, as it waits in the queue.
    typedef struct packed {
        logic [7:0]                  servo_id;
        logic [LEN_W-1:0]            len_eff;
        logic [7:0]                  len_byte;
        logic [7:0]                  command;
        logic [MAX_PAYLOAD-1:0][7:0] payload;
        logic [7:0]                  checksum;
    } frame_desc_t;

    // Queue status seen by the serialiser.
    typedef struct packed {
        logic empty;
        logic full;
    } queue_status_t;

endpackage

// File: hw/rtl/scfb_front.sv
// Front end: holds the servo id register and classifies each command word.
// Depends on scfb_pkg.
module scfb_front
    import scfb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [7:0]        cfg_wr_data,
    input  logic [7:0]        command,
    input  logic [LEN_W-1:0]  payload_len,
    input  logic [7:0]        payload_0,
    input  logic [7:0]        payload_1,
    input  logic [7:0]        payload_2,
    input  logic [7:0]        payload_3,
    output frame_desc_t       desc
);

    logic [7:0]                     servo_id_reg;
    logic [7:0]                     servo_id_next;
    logic [PAYLOAD_FIELDS-1:0][7:0] fields;
    logic [LEN_W-1:0]               len_sat;
    logic [7:0]                     sum;

    // Servo id register, written from the configuration port.
    always_comb
    begin
        servo_id_next = cfg_wr_en ? cfg_wr_data : servo_id_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            servo_id_reg <= 8'd1;
        end
        else
        begin
            servo_id_reg <= servo_id_next;
        end
    end

    assign fields = {payload_3, payload_2, payload_1, payload_0};

    // Saturate the length, pick payload bytes and form the checksum.
    always_comb
    begin
        if (payload_len > LEN_W'(MAX_PAYLOAD))
        begin
            len_sat = LEN_W'(MAX_PAYLOAD);
        end
        else
        begin
            len_sat = payload_len;
        end
        desc.servo_id = servo_id_reg;
        desc.len_eff  = len_sat;
        desc.len_byte = 8'(len_sat) + LEN_OFFSET;
        desc.command  = command;
        sum = servo_id_reg + (8'(len_sat) + LEN_OFFSET) + command;
        for (int i = 0; i < MAX_PAYLOAD; i++)
        begin
            if (i < PAYLOAD_FIELDS)
            begin
                desc.payload[i] = fields[i];
            end
            else
            begin
                desc.payload[i] = 8'd0;
            end
            if (LEN_W'(i) < len_sat)
            begin
                sum = sum + desc.payload[i];
            end
        end
        desc.checksum = ~sum;
    end

endmodule

// File: hw/rtl/scfb_queue.sv
// Short queue of classified commands between the front end and the serialiser.
// Depends on scfb_pkg.
module scfb_queue
    import scfb_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  frame_desc_t   push_desc,
    input  logic          pop,
    output frame_desc_t   head_desc,
    output queue_status_t status
);

    frame_desc_t         entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage; payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_desc;
        end
    end

    assign head_desc    = entries_reg[rd_ptr_reg];
    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));

endmodule

// File: hw/rtl/scfb_back.sv
// Serialiser: takes classified commands from the queue and sends each frame
// one byte per cycle. Depends on scfb_pkg.
module scfb_back
    import scfb_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  frame_desc_t   head_desc,
    input  queue_status_t status,
    output logic          pop,
    output logic          frame_valid,
    output logic [7:0]    frame_byte,
    output logic          frame_end
);

    frame_desc_t        desc_reg;
    frame_desc_t        desc_next;
    logic               active_reg;
    logic               active_next;
    logic [POS_W-1:0]   pos_reg;
    logic [POS_W-1:0]   pos_next;
    logic               valid_reg;
    logic               valid_next;
    logic [7:0]         byte_reg;
    logic [7:0]         byte_next;
    logic               end_reg;
    logic               end_next;
    logic [POS_W-1:0]   end_pos;
    logic [POS_W-1:0]   pay_off;
    logic               last;

    // Position bookkeeping; a new frame is loaded as the last byte goes out.
    always_comb
    begin
        end_pos     = POS_PAYLOAD + POS_W'(desc_reg.len_eff);
        pay_off     = pos_reg - POS_PAYLOAD;
        last        = active_reg && (pos_reg == end_pos);
        pop         = (!active_reg || last) && !status.empty;
        desc_next   = pop ? head_desc : desc_reg;
        active_next = active_reg;
        pos_next    = pos_reg;
        if (pop)
        begin
            active_next = 1'b1;
            pos_next    = POS_HDR0;
        end
        else if (last)
        begin
            active_next = 1'b0;
        end
        else if (active_reg)
        begin
            pos_next = pos_reg + 1'b1;
        end
    end

    // Byte selection for the current position.
    always_comb
    begin
        if (pos_reg == POS_HDR0 || pos_reg == POS_HDR1)
        begin
            byte_next = FRAME_HEADER;
        end
        else if (pos_reg == POS_ID)
        begin
            byte_next = desc_reg.servo_id;
        end
        else if (pos_reg == POS_LEN)
        begin
            byte_next = desc_reg.len_byte;
        end
        else if (pos_reg == POS_CMD)
        begin
            byte_next = desc_reg.command;
        end
        else if (last)
        begin
            byte_next = desc_reg.checksum;
        end
        else
        begin
            byte_next = desc_reg.payload[pay_off[PIDX_W-1:0]];
        end
        valid_next = active_reg;
        end_next   = last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            pos_reg    <= '0;
            valid_reg  <= 1'b0;
            end_reg    <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            pos_reg    <= pos_next;
            valid_reg  <= valid_next;
            end_reg    <= end_next;
        end
    end

    // Descriptor and output byte carry no reset.
    always_ff @(posedge clk)
    begin
        desc_reg <= desc_next;
        byte_reg <= byte_next;
    end

    assign frame_valid = valid_reg;
    assign frame_byte  = byte_reg;
    assign frame_end   = end_reg;

endmodule

// File: hw/rtl/servo_command_frame_builder.sv
// Servo command frame builder, top level.
// Depends on scfb_pkg, scfb_front, scfb_queue and scfb_back.
//
// Usage:
//   A command word (command, payload_len, payload_0..payload_3) is taken at
//   a rising edge with start high and busy low. busy is high only while the
//   two-entry command queue is full.
//   Each command becomes a frame of 6 + len bytes (len saturated at 4):
//   two 0x55 header bytes, servo id, length, command, payload, checksum.
//   Each frame byte appears on frame_byte for one cycle with frame_valid
//   high; frame_end marks the checksum byte. The receiver cannot stall.
//   When the serialiser is free, a command passes the queue entry, the
//   serialiser's descriptor and position registers and the output byte
//   register before its first byte shows. Frame bytes come one per cycle
//   within a frame; frames follow with no gap while the next one is queued.
//   The servo id register is written with cfg_wr_en and cfg_wr_data; the
//   user must write it only while the block is idle, unenforced by the block.
//   It resets to 1. Reset empties the queue and stops any frame in progress.
module servo_command_frame_builder
    import scfb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [7:0]        cfg_wr_data,
    input  logic              start,
    output logic              busy,
    input  logic [7:0]        command,
    input  logic [LEN_W-1:0]  payload_len,
    input  logic [7:0]        payload_0,
    input  logic [7:0]        payload_1,
    input  logic [7:0]        payload_2,
    input  logic [7:0]        payload_3,
    output logic              frame_valid,
    output logic [7:0]        frame_byte,
    output logic              frame_end
);

    frame_desc_t   new_desc;
    frame_desc_t   head_desc;
    queue_status_t q_status;
    logic          push;
    logic          pop;

    // A command word is accepted whenever the queue has room.
    assign busy = q_status.full;
    assign push = start && !busy;

    scfb_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .command     (command),
        .payload_len (payload_len),
        .payload_0   (payload_0),
        .payload_1   (payload_1),
        .payload_2   (payload_2),
        .payload_3   (payload_3),
        .desc        (new_desc)
    );

    scfb_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (new_desc),
        .pop       (pop),
        .head_desc (head_desc),
        .status    (q_status)
    );

    scfb_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_desc   (head_desc),
        .status      (q_status),
        .pop         (pop),
        .frame_valid (frame_valid),
        .frame_byte  (frame_byte),
        .frame_end   (frame_end)
    );

`ifndef SYNTHESIS
    // The end mark only ever accompanies a valid word.
    a_end_valid: assert property (@(posedge clk) disable iff (!rst_n)
        frame_end |-> frame_valid)
        else $error("frame_end without frame_valid");

    // A frame has at least six bytes, so two ends never come back to back.
    a_end_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        frame_end |=> !frame_end)
        else $error("consecutive frame_end");

    // Within a frame the bytes come without a gap.
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (frame_valid && !frame_end) |=> frame_valid)
        else $error("gap inside a frame");

    // A frame that directly follows another opens with the header byte.
    a_header_first: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(frame_end) && frame_valid) |-> (frame_byte == FRAME_HEADER))
        else $error("frame does not start with header");
`endif

endmodule
